[rtl/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs_pkg
// Shared payload widths and request codes for the chained hash set unit.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int KEY_IN_W   = 32;

  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

endpackage

[rtl/chs_req_if.sv]
// ----------------------------------------------------------------------------
// chs_req_if
// Request channel: insert, lookup or clear, with the key.
// ----------------------------------------------------------------------------
interface chs_req_if;
  logic                              valid;
  logic                              ready;
  logic [chs_pkg::REQ_TYPE_W-1:0]    req_type;
  logic [chs_pkg::KEY_IN_W-1:0]      key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

[rtl/chs_resp_if.sv]
// ----------------------------------------------------------------------------
// chs_resp_if
// Response channel: hit and pool-full flags, one per request.
// ----------------------------------------------------------------------------
interface chs_resp_if;
  logic valid;
  logic ready;
  logic hit;
  logic pool_full;

  modport source (output valid, output hit, output pool_full, input ready);
  modport sink   (input valid, input hit, input pool_full, output ready);
endinterface

[rtl/chained_hash_set_epoch_clear_unit.sv]
// ----------------------------------------------------------------------------
// chained_hash_set_epoch_clear_unit
// Hash set with epoch-tagged buckets and a bump-allocated overflow node pool.
// ----------------------------------------------------------------------------
//   channel  direction  payload                  transfer when
//   req      in         req_type, key            req.valid & req.ready
//   resp     out        hit, pool_full           resp.valid & resp.ready
//
// Insert and lookup compute the bucket index (the low key bits for a
// power-of-two table depth, otherwise ceil(KEY_WIDTH/4) four-bit remainder
// steps), read the bucket, read each chain node from the pool RAM, and
// load the response; req.ready returns in the cycle after that. A clear
// that keeps the epoch, and an unknown request, go straight to the response
// load; a new request is taken only once that response is loaded. After
// reset, and on a clear that wraps the epoch, tags are swept with req.ready
// low. A stalled response holds; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_set_epoch_clear_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int POOL_DEPTH  = 1024,
  parameter int KEY_WIDTH   = 32,
  parameter int EPOCH_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  chs_req_if.sink     req,
  chs_resp_if.source  resp
);

  localparam int BW    = $clog2(TABLE_DEPTH);
  localparam int LW    = $clog2(POOL_DEPTH + 1);
  localparam int NW    = POOL_DEPTH > 1 ? $clog2(POOL_DEPTH) : 1;
  localparam int KW    = KEY_WIDTH;
  localparam int EW    = EPOCH_WIDTH;
  localparam int BWORD = KW + EW + LW;
  localparam int NWORD = KW + LW;

  localparam logic [2:0] S_SWEEP     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_HASH      = 3'd2;
  localparam logic [2:0] S_BUCKET    = 3'd3;
  localparam logic [2:0] S_WALK_INS  = 3'd4;
  localparam logic [2:0] S_WALK_LOOK = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]                      state;
  logic [BW-1:0]                   sweep_addr;
  logic                            sweep_reply;
  logic [chs_pkg::REQ_TYPE_W-1:0]  req_q;
  logic [KW-1:0]                   key_q;
  logic [BW-1:0]                   bidx;
  logic [LW-1:0]                   cur;
  logic [LW-1:0]                   alloc;
  logic [LW-1:0]                   nodes_used;
  logic [EW-1:0]                   epoch;
  logic                            hit_r;
  logic                            full_r;
  logic                            out_valid;
  logic                            out_hit;
  logic                            out_full;

  logic                            accept;
  logic                            mod_start;
  logic                            mod_done;
  logic [BW-1:0]                   mod_rem;

  logic                            b_we;
  logic [BW-1:0]                   b_waddr;
  logic [BWORD-1:0]                b_wdata;
  logic                            b_re;
  logic [BWORD-1:0]                b_rdata;
  logic [KW-1:0]                   bkey;
  logic [EW-1:0]                   btag;
  logic [LW-1:0]                   blink;

  logic                            n_we;
  logic [NW-1:0]                   n_waddr;
  logic [NWORD-1:0]                n_wdata;
  logic                            n_re;
  logic [NW-1:0]                   n_raddr;
  logic [NWORD-1:0]                n_rdata;
  logic [KW-1:0]                   nkey;
  logic [LW-1:0]                   nlink;

  logic                            live;
  logic                            pool_exh;
  logic                            is_ins;
  logic [LW-1:0]                   blink_m1;
  logic [LW-1:0]                   nlink_m1;
  logic [LW-1:0]                   cur_m1;
  logic [EW-1:0]                   epoch_inc;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign mod_start = accept &&
                     (req.req_type == chs_pkg::REQ_INSERT ||
                      req.req_type == chs_pkg::REQ_LOOKUP);

  assign {bkey, btag, blink} = b_rdata;
  assign {nkey, nlink}       = n_rdata;

  assign live      = (btag == epoch);
  assign pool_exh  = (nodes_used == LW'(POOL_DEPTH));
  assign is_ins    = (req_q == chs_pkg::REQ_INSERT);
  assign blink_m1  = blink - 1'b1;
  assign nlink_m1  = nlink - 1'b1;
  assign cur_m1    = cur - 1'b1;
  assign epoch_inc = epoch + 1'b1;

  chs_mod_unit #(
    .DEPTH (TABLE_DEPTH),
    .VAL_W (KW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (KW'(req.key)),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  chs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (BWORD)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (mod_rem),
    .rdata (b_rdata)
  );

  chs_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (NWORD)
  ) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .re    (n_re),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  // Bucket RAM port control.
  always_comb begin
    b_we    = 1'b0;
    b_waddr = bidx;
    b_wdata = {key_q, epoch, LW'(0)};
    b_re    = (state == S_HASH) && mod_done;
    if (state == S_SWEEP) begin
      b_we    = 1'b1;
      b_waddr = sweep_addr;
      b_wdata = '0;
    end else if (state == S_BUCKET && is_ins) begin
      if (!live) begin
        b_we = 1'b1;
      end else if (!pool_exh && blink == '0) begin
        // First overflow node hangs directly off the head.
        b_we    = 1'b1;
        b_wdata = {bkey, btag, nodes_used + 1'b1};
      end
    end
  end

  // Pool RAM port control. The new node never lies on the chain being read.
  always_comb begin
    n_we    = 1'b0;
    n_waddr = nodes_used[NW-1:0];
    n_wdata = {key_q, LW'(0)};
    n_re    = 1'b0;
    n_raddr = blink_m1[NW-1:0];
    case (state)
      S_BUCKET: begin
        if (is_ins) begin
          if (live && !pool_exh) begin
            n_we = 1'b1;
            n_re = (blink != '0);
          end
        end else if (live && bkey != key_q && blink != '0) begin
          n_re = 1'b1;
        end
      end
      S_WALK_INS: begin
        if (nlink == '0) begin
          n_we    = 1'b1;
          n_waddr = cur_m1[NW-1:0];
          n_wdata = {nkey, alloc};
        end else begin
          n_re    = 1'b1;
          n_raddr = nlink_m1[NW-1:0];
        end
      end
      S_WALK_LOOK: begin
        n_re    = (nkey != key_q) && (nlink != '0);
        n_raddr = nlink_m1[NW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      nodes_used  <= '0;
      epoch       <= EW'(1);
      out_valid   <= 1'b0;
    end else begin
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == BW'(TABLE_DEPTH - 1)) begin
            sweep_addr <= '0;
            state      <= sweep_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (mod_start) begin
              state <= S_HASH;
            end else if (req.req_type == chs_pkg::REQ_CLEAR) begin
              nodes_used <= '0;
              if (epoch_inc == '0) begin
                epoch       <= EW'(1);
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end else begin
                epoch <= epoch_inc;
                state <= S_DONE;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state <= S_BUCKET;
          end
        end
        S_BUCKET: begin
          state <= S_DONE;
          if (is_ins) begin
            if (live && !pool_exh) begin
              nodes_used <= nodes_used + 1'b1;
              if (blink != '0) begin
                state <= S_WALK_INS;
              end
            end
          end else if (live && bkey != key_q && blink != '0) begin
            state <= S_WALK_LOOK;
          end
        end
        S_WALK_INS: begin
          if (nlink == '0) begin
            state <= S_DONE;
          end
        end
        S_WALK_LOOK: begin
          if (nkey == key_q || nlink == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || resp.ready) begin
            state       <= S_IDLE;
            sweep_reply <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (state == S_DONE && (!out_valid || resp.ready)) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end

    // Payload registers.
    if (accept) begin
      req_q  <= req.req_type;
      key_q  <= KW'(req.key);
      hit_r  <= 1'b0;
      full_r <= 1'b0;
    end
    if (state == S_HASH && mod_done) begin
      bidx <= mod_rem;
    end
    if (state == S_BUCKET) begin
      cur   <= blink;
      alloc <= nodes_used + 1'b1;
      if (is_ins) begin
        hit_r  <= live;
        full_r <= live && pool_exh;
      end else begin
        hit_r <= live && (bkey == key_q);
      end
    end
    if (state == S_WALK_INS) begin
      cur <= nlink;
    end
    if (state == S_WALK_LOOK && nkey == key_q) begin
      hit_r <= 1'b1;
    end
    if (state == S_DONE && (!out_valid || resp.ready)) begin
      out_hit  <= hit_r;
      out_full <= full_r;
    end
  end

  assign resp.valid     = out_valid;
  assign resp.hit       = out_hit;
  assign resp.pool_full = out_full;

endmodule

[rtl/chs_ram.sv]
// ----------------------------------------------------------------------------
// chs_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/chs_mod_unit.sv]
// ----------------------------------------------------------------------------
// chs_mod_unit
// Bucket index unit: remainder of the key by the table depth.
// ----------------------------------------------------------------------------
module chs_mod_unit #(
  parameter int DEPTH = 256,
  parameter int VAL_W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [VAL_W-1:0]           value,
  output logic                       done,
  output logic [$clog2(DEPTH)-1:0]   rem
);

  localparam int RW = $clog2(DEPTH);

  generate
    if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
      // A power-of-two depth is just the low bits of the key.
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          rem <= RW'(value);
        end
      end
    end else begin : g_iter
      // Restoring remainder, four key bits per cycle, most significant first.
      localparam int DIGIT = 4;
      localparam int NSTEP = (VAL_W + DIGIT - 1) / DIGIT;
      localparam int PW    = NSTEP * DIGIT;
      localparam int CW    = $clog2(NSTEP + 1);
      localparam logic [RW:0] DEPTH_C = (RW + 1)'(DEPTH);

      logic [PW-1:0] shreg;
      logic [RW-1:0] r;
      logic [RW-1:0] r_new;
      logic [CW-1:0] cnt;
      logic          busy;

      always_comb begin
        logic [RW:0] t;
        r_new = r;
        for (int i = 0; i < DIGIT; i++) begin
          t = {r_new, shreg[PW-1-i]};
          if (t >= DEPTH_C) begin
            t = t - DEPTH_C;
          end
          r_new = t[RW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= CW'(NSTEP);
          end else if (busy) begin
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
        if (start) begin
          shreg <= PW'(value);
          r     <= '0;
        end else if (busy) begin
          shreg <= shreg << DIGIT;
          r     <= r_new;
        end
      end

      assign rem = r;
    end
  endgenerate

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained hash set unit. Requests go in through the
// request channel with random gaps. Each accepted transfer updates a model of
// the set, held in a small scoreboard. The scoreboard checks each response
// transfer against the oldest expected flag pair. The stimulus builds chains
// and fills the node pool to exhaustion, and clears often enough to wrap the
// epoch.
// ----------------------------------------------------------------------------
module tb;

  localparam int TABLE_DEPTH = 256;
  localparam int POOL_DEPTH  = 1024;
  localparam int EPOCH_W     = 8;
  localparam int LINK_W      = 11;
  localparam int ITEM_TARGET = 1950;

  localparam logic [chs_pkg::REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

  class hash_set_scoreboard;
    typedef struct packed {
      logic hit;
      logic pool_full;
    } resp_flags_t;

    logic [chs_pkg::KEY_IN_W-1:0] head_key  [TABLE_DEPTH];
    logic [EPOCH_W-1:0]           head_tag  [TABLE_DEPTH];
    logic [LINK_W-1:0]            head_link [TABLE_DEPTH];
    logic [chs_pkg::KEY_IN_W-1:0] node_key  [POOL_DEPTH];
    logic [LINK_W-1:0]            node_link [POOL_DEPTH];
    logic [LINK_W-1:0]            nodes_used;
    logic [EPOCH_W-1:0]           epoch;
    int                           wraps;
    int                           fail_count;
    resp_flags_t                  expected_flags [$];

    function new();
      foreach (head_tag[i]) begin
        head_key[i]  = '0;
        head_tag[i]  = '0;
        head_link[i] = '0;
      end
      foreach (node_key[i]) begin
        node_key[i]  = '0;
        node_link[i] = '0;
      end
      nodes_used = '0;
      epoch      = 'd1;
      wraps      = 0;
      fail_count = 0;
    endfunction

    // Applies one accepted request to the set and queues the flags it yields.
    function void note_request(input logic [chs_pkg::REQ_TYPE_W-1:0] kind,
                               input logic [chs_pkg::KEY_IN_W-1:0] key);
      resp_flags_t         flags;
      logic [7:0]          bucket;
      logic [LINK_W-1:0]   link;
      logic [LINK_W-1:0]   slot;
      logic                live;
      int                  steps;
      flags  = '0;
      bucket = 8'(key % TABLE_DEPTH);
      live   = (head_tag[bucket] == epoch);
      case (kind)
        chs_pkg::REQ_INSERT: begin
          if (!live) begin
            head_key[bucket]  = key;
            head_link[bucket] = '0;
            head_tag[bucket]  = epoch;
          end else begin
            flags.hit = 1'b1;
            if (nodes_used >= POOL_DEPTH) begin
              flags.pool_full = 1'b1;
            end else begin
              slot            = nodes_used;
              nodes_used      = nodes_used + 1'b1;
              node_key[slot]  = key;
              node_link[slot] = '0;
              if (head_link[bucket] == '0) begin
                head_link[bucket] = slot + 1'b1;
              end else begin
                // Links hold index plus one, so the tail is the node whose link is zero.
                link  = head_link[bucket];
                steps = 0;
                while (node_link[link - 1'b1] != '0 && steps < POOL_DEPTH) begin
                  link = node_link[link - 1'b1];
                  steps++;
                end
                node_link[link - 1'b1] = slot + 1'b1;
              end
            end
          end
        end
        chs_pkg::REQ_LOOKUP: begin
          if (live) begin
            if (head_key[bucket] == key) begin
              flags.hit = 1'b1;
            end else begin
              link  = head_link[bucket];
              steps = 0;
              while (link != '0 && steps < POOL_DEPTH && !flags.hit) begin
                if (node_key[link - 1'b1] == key) flags.hit = 1'b1;
                else link = node_link[link - 1'b1];
                steps++;
              end
            end
          end
        end
        chs_pkg::REQ_CLEAR: begin
          epoch = epoch + 1'b1;
          if (epoch == '0) begin
            foreach (head_tag[i]) head_tag[i] = '0;
            epoch = 'd1;
            wraps++;
          end
          nodes_used = '0;
        end
        default: begin
        end
      endcase
      expected_flags.push_back(flags);
    endfunction

    function void check_response(input logic hit, input logic pool_full);
      resp_flags_t flags;
      if (expected_flags.size() == 0) begin
        $error("response with no request outstanding: hit %0b pool_full %0b",
               hit, pool_full);
        fail_count++;
        return;
      end
      flags = expected_flags.pop_front();
      if (hit !== flags.hit) begin
        $error("hit mismatch: expected %0b, actual %0b", flags.hit, hit);
        fail_count++;
      end
      if (pool_full !== flags.pool_full) begin
        $error("pool_full mismatch: expected %0b, actual %0b", flags.pool_full, pool_full);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  int   items_sent = 0;
  logic [chs_pkg::KEY_IN_W-1:0] stored_keys [$];
  hash_set_scoreboard sb = new();

  chs_req_if  req_ch ();
  chs_resp_if resp_ch ();

  chained_hash_set_epoch_clear_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POOL_DEPTH  (POOL_DEPTH),
    .KEY_WIDTH   (chs_pkg::KEY_IN_W),
    .EPOCH_WIDTH (EPOCH_W)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .resp (resp_ch)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Half the lookups aim at stored keys; the rest are random keys in the given bucket or anywhere.
  function automatic logic [chs_pkg::KEY_IN_W-1:0] lookup_key(input logic [7:0] bucket);
    logic [chs_pkg::KEY_IN_W-1:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 3))
      0, 1: if (stored_keys.size() != 0)
              return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      2: return {rnd[chs_pkg::KEY_IN_W-1:8], bucket};
      default: ;
    endcase
    return rnd;
  endfunction

  // Called at a rising edge; returns at the edge of the request transfer.
  task automatic send_request(input logic [chs_pkg::REQ_TYPE_W-1:0] kind,
                              input logic [chs_pkg::KEY_IN_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.key      <= key;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(kind, key);
    items_sent++;
    if (kind == chs_pkg::REQ_INSERT && stored_keys.size() < 256) stored_keys.push_back(key);
    if (kind == chs_pkg::REQ_CLEAR) stored_keys.delete();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    resp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
        sb.check_response(resp_ch.hit, resp_ch.pool_full);
      if (stall_left > 0) begin
        resp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        resp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic [7:0]                   focus [3];
    logic [7:0]                   bucket;
    logic [chs_pkg::KEY_IN_W-1:0] rnd;
    int                           ops;
    int                           r;
    int                           wraps_seen;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= chs_pkg::REQ_INSERT;
    req_ch.key      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: key extremes, chains in bucket 0, unknown codes and dead buckets.
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_request(chs_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_request(chs_pkg::REQ_INSERT, 32'h0000_0100);
    send_request(chs_pkg::REQ_INSERT, 32'h0000_0200);
    send_request(chs_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0200);
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0300);
    send_request(chs_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_request(chs_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
    send_request(chs_pkg::REQ_LOOKUP, 32'hFFFF_FF00);
    send_request(chs_pkg::REQ_INSERT, 32'hFFFF_FEFF);
    send_request(chs_pkg::REQ_LOOKUP, 32'hFFFF_FEFF);
    send_request(REQ_UNKNOWN, 32'hFFFF_FFFF);
    send_request(REQ_UNKNOWN, 32'h0000_0000);
    send_request(chs_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_request(chs_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
    send_request(chs_pkg::REQ_INSERT, 32'h0000_0100);
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0100);
    send_request(chs_pkg::REQ_CLEAR, 32'h0000_0000);
    send_request(chs_pkg::REQ_CLEAR, 32'h0000_0000);
    send_request(chs_pkg::REQ_INSERT, 32'h8000_0000);
    send_request(chs_pkg::REQ_LOOKUP, 32'h8000_0000);

    // Pool fill: keys spread over 64 buckets until the pool runs out and
    // further collisions are dropped.
    send_request(chs_pkg::REQ_CLEAR, $urandom);
    for (int i = 0; i < 64 + POOL_DEPTH + 16; i++) begin
      if (i % 200 == 0) calm = ($urandom_range(0, 1) == 0);
      rnd = $urandom;
      if ($urandom_range(0, 24) == 0)
        send_request(chs_pkg::REQ_LOOKUP, lookup_key(rnd[7:0] & 8'h3F));
      send_request(chs_pkg::REQ_INSERT, rnd & 32'hFFFF_FF3F);
    end

    // Short rounds, each opened by a clear, until the item target is reached and the epoch has wrapped.
    wraps_seen = 0;
    while (items_sent < ITEM_TARGET || sb.wraps == 0) begin
      calm = ($urandom_range(0, 4) == 0);
      send_request(chs_pkg::REQ_CLEAR, $urandom);
      if (sb.wraps != wraps_seen) begin
        // Buckets filled in epoch one long ago must read as dead after the sweep.
        wraps_seen = sb.wraps;
        send_request(chs_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
        send_request(chs_pkg::REQ_LOOKUP, 32'h0000_0000);
      end
      foreach (focus[j]) focus[j] = 8'($urandom);
      if ($urandom_range(0, 3) == 0) focus[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      ops = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(6, 16);
      repeat (ops) begin
        r      = $urandom_range(0, 99);
        bucket = focus[$urandom_range(0, 2)];
        rnd    = $urandom;
        if (r < 45) send_request(chs_pkg::REQ_INSERT, {rnd[chs_pkg::KEY_IN_W-1:8], bucket});
        else if (r < 48) send_request(chs_pkg::REQ_INSERT, rnd);
        else if (r < 53) send_request(chs_pkg::REQ_INSERT, lookup_key(bucket));
        else if (r < 96) send_request(chs_pkg::REQ_LOOKUP, lookup_key(bucket));
        else send_request(REQ_UNKNOWN, rnd);
      end
    end

    req_ch.valid <= 1'b0;
    while (sb.expected_flags.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
